// ===== rtl/pomdp_belief_update_core_defines.svh =====
// Assertion helpers for the belief update core.
// Both expect signals named clk and arst_n in the using module.
`ifndef POMDP_BELIEF_UPDATE_CORE_DEFINES_SVH
`define POMDP_BELIEF_UPDATE_CORE_DEFINES_SVH

// same-cycle implication
`define PBU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PBU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pbu_pkg.sv =====
// ----------------------------------------------------------------------------
// pbu_pkg
// Shared constants and types of the belief update core.
// ----------------------------------------------------------------------------
`default_nettype none

package pbu_pkg;

	// port field widths
	localparam int REQ_W   = 2;
	localparam int ACT_W   = 2;
	localparam int ST_W    = 4;
	localparam int OBS_W   = 3;
	localparam int PROB_W  = 17;
	localparam int CFGI_W  = 2;
	localparam int CFGD_W  = 16;
	localparam int NS_W    = 5;
	localparam int MASK_W  = 16;
	localparam int MAXRES  = 16;

	// request codes
	localparam logic [REQ_W-1:0] REQ_WR_TRANS = 2'd0;
	localparam logic [REQ_W-1:0] REQ_WR_OBS   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_WR_BEL   = 2'd2;
	localparam logic [REQ_W-1:0] REQ_STEP     = 2'd3;

	// register indexes
	localparam logic [CFGI_W-1:0] CFG_NUM_STATES = 2'd0;
	localparam logic [CFGI_W-1:0] CFG_TARGET_MASK = 2'd1;

	typedef struct packed {
		logic trans_we;
		logic trans_re;
		logic obs_we;
		logic obs_re;
	} pbu_mem_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/pbu_tables.sv =====
// ----------------------------------------------------------------------------
// pbu_tables
// Transition and observation tables, single port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pbu_tables #(
	parameter int PW     = 17,
	parameter int TDEPTH = 1024,
	parameter int ODEPTH = 512,
	parameter int TAW    = 10,
	parameter int OAW    = 9
) (
	input  wire                  clk,
	input  pbu_pkg::pbu_mem_ctl_t ctl,
	input  wire [TAW-1:0]        trans_addr,
	input  wire [OAW-1:0]        obs_addr,
	input  wire [PW-1:0]         wdata,
	output logic [PW-1:0]        trans_rdata,
	output logic [PW-1:0]        obs_rdata
);

	logic [PW-1:0] trans_mem [TDEPTH];
	logic [PW-1:0] obs_mem [ODEPTH];

	always_ff @(posedge clk) begin
		if (ctl.trans_we) begin
			trans_mem[trans_addr] <= wdata;
		end
		if (ctl.trans_re) begin
			trans_rdata <= trans_mem[trans_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.obs_we) begin
			obs_mem[obs_addr] <= wdata;
		end
		if (ctl.obs_re) begin
			obs_rdata <= obs_mem[obs_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pbu_divider.sv =====
// ----------------------------------------------------------------------------
// pbu_divider
// Restoring fraction divider: floor(num * 2^FRAC / den), one bit a cycle,
// result 1.0 when num >= den.
// ----------------------------------------------------------------------------
`default_nettype none

module pbu_divider #(
	parameter int FRAC = 16,
	parameter int NW   = 39,
	parameter int DW   = 43
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  wire [NW-1:0]        num,
	input  wire [DW-1:0]        den,
	output logic                done,
	output logic [FRAC:0]       quot
);

	localparam int CW = $clog2(FRAC + 1);

	logic [DW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   rem2;
	logic          fits;

	assign rem2 = {rem_q, 1'b0};
	assign fits = rem2 >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done   <= 1'b0;
			quot   <= '0;
		end else if (start) begin
			if (DW'(num) >= den) begin
				quot   <= {1'b1, {FRAC{1'b0}}};
				done   <= 1'b1;
				busy_q <= 1'b0;
			end else begin
				rem_q  <= DW'(num);
				quot   <= '0;
				cnt_q  <= CW'(FRAC);
				busy_q <= 1'b1;
				done   <= 1'b0;
			end
		end else if (busy_q) begin
			rem_q <= fits ? DW'(rem2 - {1'b0, den}) : DW'(rem2);
			quot  <= {quot[FRAC-1:0], fits};
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done   <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pomdp_belief_update_core.sv =====
// ----------------------------------------------------------------------------
// pomdp_belief_update_core
// Forward belief update: prediction through the transition table, weighting
// by the observation table, normalization into a new stored belief.
// ----------------------------------------------------------------------------
// Table and belief writes are registered. A step with n active states runs,
// per destination state, one MAC per cycle through the single-port transition
// memory, a drain of the MAC pipeline (s1, s2), then the likelihood product
// (ST_WMUL) and the sum (ST_WACC). The bit-serial normalizing divider then
// runs once per state, and a state whose weight reaches the total gets 1.0
// without iteration. Results stall the step while the output register is full.
// The tables and belief read as undefined until written; there is no clearing
// pass after reset.
`default_nettype none

`include "pomdp_belief_update_core_defines.svh"

module pomdp_belief_update_core #(
	parameter int NSTATES   = 16,
	parameter int NACTIONS  = 4,
	parameter int NOBS      = 8,
	parameter int PROB_FRAC = 16
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire [pbu_pkg::REQ_W-1:0]          req_type,
	input  wire [pbu_pkg::ACT_W-1:0]          action,
	input  wire [pbu_pkg::ST_W-1:0]           from_state,
	input  wire [pbu_pkg::ST_W-1:0]           to_state,
	input  wire [pbu_pkg::OBS_W-1:0]          observation,
	input  wire [pbu_pkg::PROB_W-1:0]         prob_value,
	input  wire                               absorb,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic [pbu_pkg::ST_W-1:0]          state_index,
	output logic [pbu_pkg::PROB_W-1:0]        posterior,
	output logic [pbu_pkg::PROB_W-1:0]        obs_prob,
	output logic                              zero_prob,
	output logic                              last,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire [pbu_pkg::CFGI_W-1:0]         cfg_index,
	input  wire [pbu_pkg::CFGD_W-1:0]         cfg_data
);

	localparam int PW     = PROB_FRAC + 1;
	localparam int SW     = $clog2(NSTATES);
	localparam int TDEPTH = NACTIONS * NSTATES * NSTATES;
	localparam int ODEPTH = NACTIONS * NSTATES * NOBS;
	localparam int TAW    = $clog2(TDEPTH);
	localparam int OAW    = $clog2(ODEPTH);
	localparam int NMAX   = NSTATES < pbu_pkg::MAXRES ? NSTATES : pbu_pkg::MAXRES;
	localparam int PRODW  = 2 * PW;
	localparam int ACCW   = PRODW + 4;
	localparam int PREDW  = ACCW - PROB_FRAC;
	localparam int WW     = PREDW + PW;
	localparam int POW    = WW + 4;
	localparam int NSW    = pbu_pkg::NS_W;
	localparam logic [PW-1:0] ONE = {1'b1, {PROB_FRAC{1'b0}}};

	typedef enum logic [3:0] {
		ST_IDLE, ST_ROW, ST_WMUL, ST_WACC, ST_CHECK, ST_DIV, ST_DWAIT, ST_FLAG
	} state_t;

	state_t state_q;

	logic [NSW-1:0]               num_states_q;
	logic [pbu_pkg::MASK_W-1:0]   target_mask_q;
	logic [NSW-1:0]               n_act, n_q, sp_q, iss_q;
	logic [pbu_pkg::ACT_W-1:0]    a_q;
	logic [pbu_pkg::OBS_W-1:0]    o_q;
	logic                         absorb_q;
	logic [POW-1:0]               po_q;
	logic [PW-1:0]                opr_q, opr_sat;
	logic [POW-1:0]               po_hi;

	logic [PW-1:0]                belief_q [NSTATES];
	logic [WW-1:0]                wbuf_q [NSTATES];

	logic                         in_acc, issue, row_drained, out_free, emit, last_el;
	logic                         step_bad, wr_ok_t, wr_ok_o, wr_ok_b;
	logic [PW-1:0]                pv_sat;
	pbu_pkg::pbu_mem_ctl_t        mem_ctl;
	logic [TAW-1:0]               trans_addr;
	logic [OAW-1:0]               obs_addr;
	logic [PW-1:0]                trans_rdata, obs_rdata;

	logic                         v_s1, v_s2, ovr_s1, self_s1;
	logic [PW-1:0]                b_s1, t_val;
	logic [PRODW-1:0]             prod_s2;
	logic [ACCW-1:0]              acc_q;
	logic [WW-1:0]                w_q;

	logic                         dv_start, dv_done;
	logic [PW-1:0]                dv_quot;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_states_q  <= NSW'(16);
			target_mask_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				pbu_pkg::CFG_NUM_STATES:  num_states_q  <= cfg_data[NSW-1:0];
				pbu_pkg::CFG_TARGET_MASK: target_mask_q <= cfg_data[pbu_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (num_states_q == '0) begin
			n_act = NSW'(1);
		end else if (int'(num_states_q) > NMAX) begin
			n_act = NSW'(NMAX);
		end else begin
			n_act = num_states_q;
		end
	end

	// request decode
	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign pv_sat   = (int'(prob_value) > (1 << PROB_FRAC)) ? ONE : PW'(prob_value);
	assign wr_ok_t  = int'(action) < NACTIONS && int'(from_state) < NSTATES &&
		int'(to_state) < NSTATES;
	assign wr_ok_o  = int'(action) < NACTIONS && int'(to_state) < NSTATES &&
		int'(observation) < NOBS;
	assign wr_ok_b  = int'(to_state) < NSTATES;
	assign step_bad = int'(action) >= NACTIONS || int'(observation) >= NOBS;

	assign issue       = (state_q == ST_ROW) && (iss_q < n_q);
	assign row_drained = (state_q == ST_ROW) && (iss_q == n_q) && !v_s1 && !v_s2;
	assign out_free    = !out_valid || out_ready;
	assign last_el     = (sp_q + NSW'(1)) == n_q;
	assign emit        = (state_q == ST_DWAIT) && dv_done && out_free;
	assign dv_start    = (state_q == ST_DIV);

	always_comb begin
		mem_ctl.trans_we = in_acc && req_type == pbu_pkg::REQ_WR_TRANS && wr_ok_t;
		mem_ctl.obs_we   = in_acc && req_type == pbu_pkg::REQ_WR_OBS && wr_ok_o;
		mem_ctl.trans_re = issue;
		mem_ctl.obs_re   = issue && iss_q == '0;
		if (state_q == ST_IDLE) begin
			trans_addr = TAW'((int'(action) * NSTATES + int'(from_state)) * NSTATES +
				int'(to_state));
			obs_addr   = OAW'((int'(action) * NSTATES + int'(to_state)) * NOBS +
				int'(observation));
		end else begin
			trans_addr = TAW'((int'(a_q) * NSTATES + int'(iss_q)) * NSTATES + int'(sp_q));
			obs_addr   = OAW'((int'(a_q) * NSTATES + int'(sp_q)) * NOBS + int'(o_q));
		end
	end

	pbu_tables #(
		.PW     (PW),
		.TDEPTH (TDEPTH),
		.ODEPTH (ODEPTH),
		.TAW    (TAW),
		.OAW    (OAW)
	) u_tables (
		.clk         (clk),
		.ctl         (mem_ctl),
		.trans_addr  (trans_addr),
		.obs_addr    (obs_addr),
		.wdata       (pv_sat),
		.trans_rdata (trans_rdata),
		.obs_rdata   (obs_rdata)
	);

	// MAC pipeline: issue -> s1 (memory data) -> s2 (product) -> accumulate
	// absorbing targets override the table with a self loop
	assign t_val = ovr_s1 ? (self_s1 ? ONE : '0) : trans_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		b_s1    <= belief_q[SW'(iss_q)];
		ovr_s1  <= absorb_q && target_mask_q[iss_q[3:0]];
		self_s1 <= iss_q == sp_q;
		prod_s2 <= b_s1 * t_val;
		if (state_q == ST_IDLE || state_q == ST_WACC) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACCW'(prod_s2);
		end
		if (state_q == ST_WMUL) begin
			w_q <= WW'(acc_q[ACCW-1:PROB_FRAC] * obs_rdata);
		end
		if (state_q == ST_WACC) begin
			wbuf_q[SW'(sp_q)] <= w_q;
		end
		if (in_acc && req_type == pbu_pkg::REQ_WR_BEL && wr_ok_b) begin
			belief_q[SW'(to_state)] <= pv_sat;
		end else if (emit) begin
			belief_q[SW'(sp_q)] <= dv_quot;
		end
	end

	pbu_divider #(
		.FRAC (PROB_FRAC),
		.NW   (WW),
		.DW   (POW)
	) u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.num    (wbuf_q[SW'(sp_q)]),
		.den    (po_q),
		.done   (dv_done),
		.quot   (dv_quot)
	);

	assign po_hi   = po_q >> (2 * PROB_FRAC);
	assign opr_sat = (po_hi > POW'(ONE)) ? ONE : PW'(po_hi);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			sp_q        <= '0;
			iss_q       <= '0;
			a_q         <= '0;
			o_q         <= '0;
			absorb_q    <= 1'b0;
			po_q        <= '0;
			opr_q       <= '0;
			out_valid   <= 1'b0;
			state_index <= '0;
			posterior   <= '0;
			obs_prob    <= '0;
			zero_prob   <= 1'b0;
			last        <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && req_type == pbu_pkg::REQ_STEP) begin
						a_q      <= action;
						o_q      <= observation;
						absorb_q <= absorb;
						n_q      <= n_act;
						sp_q     <= '0;
						iss_q    <= '0;
						po_q     <= '0;
						state_q  <= step_bad ? ST_FLAG : ST_ROW;
					end
				end
				ST_ROW: begin
					if (issue) begin
						iss_q <= iss_q + NSW'(1);
					end
					if (row_drained) begin
						state_q <= ST_WMUL;
					end
				end
				ST_WMUL: state_q <= ST_WACC;
				ST_WACC: begin
					po_q  <= po_q + POW'(w_q);
					iss_q <= '0;
					if (last_el) begin
						sp_q    <= '0;
						state_q <= ST_CHECK;
					end else begin
						sp_q    <= sp_q + NSW'(1);
						state_q <= ST_ROW;
					end
				end
				ST_CHECK: begin
					opr_q   <= opr_sat;
					state_q <= (po_q == '0) ? ST_FLAG : ST_DIV;
				end
				ST_DIV: state_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (emit) begin
						out_valid   <= 1'b1;
						state_index <= pbu_pkg::ST_W'(sp_q);
						posterior   <= pbu_pkg::PROB_W'(dv_quot);
						obs_prob    <= pbu_pkg::PROB_W'(opr_q);
						zero_prob   <= 1'b0;
						last        <= last_el;
						if (last_el) begin
							state_q <= ST_IDLE;
						end else begin
							sp_q    <= sp_q + NSW'(1);
							state_q <= ST_DIV;
						end
					end
				end
				ST_FLAG: begin
					if (out_free) begin
						out_valid   <= 1'b1;
						state_index <= '0;
						posterior   <= '0;
						obs_prob    <= '0;
						zero_prob   <= 1'b1;
						last        <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`PBU_ASSERT_IMP(a_flag_is_last, out_valid && zero_prob, last && posterior == '0,
		"flagged result must be the only one of its step")
	`PBU_ASSERT_IMP(a_sp_in_range, state_q == ST_DWAIT, sp_q < n_q,
		"posterior index beyond active states")
	`PBU_ASSERT_IMP(a_mac_in_row, state_q != ST_ROW, !v_s1 && !v_s2,
		"MAC pipeline busy outside a row")
	`PBU_ASSERT_NXT(a_div_restart, dv_start, !dv_start,
		"divider started twice in a row")

endmodule

`default_nettype wire
